// ----- rtl/core/pli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list package
// Opcodes, status codes, field widths and the control word that the list
// controller hands to every storage cell.
// ----------------------------------------------------------------------------
package pli_pkg;

	// Fixed widths of the item fields.
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Request opcodes.
	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_BACK  = 3'd4,
		OP_DEL_POS   = 3'd5
	} opcode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Per-cell control: the operation being committed and where the cell
	// sits relative to the target position.
	typedef struct packed {
		logic ins;   // a successful insert is committed this cycle
		logic del;   // a successful delete is committed this cycle
		logic hit;   // this cell is the target position
		logic past;  // this cell lies after the target position
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/pli_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list storage cell
// Holds one list entry and shifts toward the back on an insert or toward
// the front on a delete, taking data from its neighbor.
// ----------------------------------------------------------------------------
module pli_cell (
	input  wire                                 clk,
	input  wire pli_pkg::cell_ctl_t             ctl,
	input  wire logic signed [pli_pkg::DATA_W-1:0] word,
	input  wire logic signed [pli_pkg::DATA_W-1:0] left,
	input  wire logic signed [pli_pkg::DATA_W-1:0] right,
	output logic signed [pli_pkg::DATA_W-1:0]      entry
);

	logic signed [pli_pkg::DATA_W-1:0] entry_q;

	// An insert writes the new word at the target and moves later entries
	// back by one; a delete pulls the target and later entries forward.
	always_ff @(posedge clk) begin
		if (ctl.ins && ctl.hit) begin
			entry_q <= word;
		end else if (ctl.ins && ctl.past) begin
			entry_q <= left;
		end else if (ctl.del && (ctl.hit || ctl.past)) begin
			entry_q <= right;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// ----- rtl/core/positional_list_insert_delete_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional list, top level
// Bounded ordered list of signed words with insert and delete at the front,
// at the back or at a given position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one request item (opcode, data_value, position)
// and is accepted when in_valid is high and in_stall is low. Every request
// gives exactly one result item (status, removed_value, entry_count) on the
// output channel, taken when out_valid is high and out_stall is low.
// The result is loaded into the output register at the edge that accepts the
// request and is offered on the output channel in the following cycle.
// Throughput is one item per cycle while the receiver does not stall, because
// every cell shifts in parallel with its neighbor in the same cycle that the
// request is committed; the shift of DEPTH cells is the only work.
// When the receiver stalls, the result stays in the output register and
// in_stall goes high until it is taken; the list does not change meanwhile.
// Reset empties the list and clears the output valid; the entries
// themselves are not cleared, since no request reads past the count.
// A failed request returns its status code and leaves the list unchanged.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top #(
	parameter int DEPTH = 16
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     in_valid,
	output logic                                    in_stall,
	input  wire logic [pli_pkg::OP_W-1:0]           opcode,
	input  wire logic signed [pli_pkg::DATA_W-1:0]  data_value,
	input  wire logic [pli_pkg::POS_W-1:0]          position,
	output logic                                    out_valid,
	input  wire                                     out_stall,
	output logic [pli_pkg::STATUS_W-1:0]            status,
	output logic signed [pli_pkg::DATA_W-1:0]       removed_value,
	output logic [pli_pkg::COUNT_W-1:0]             entry_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > pli_pkg::POS_W) ? CNT_W : pli_pkg::POS_W;

	logic [CNT_W-1:0]                     count_q;
	logic [CNT_W-1:0]                     count_d;
	logic                                 out_valid_q;
	pli_pkg::status_t                     status_q;
	logic signed [pli_pkg::DATA_W-1:0]    removed_q;
	logic [pli_pkg::COUNT_W-1:0]          entry_count_q;

	logic                                 accept;
	logic                                 is_ins;
	logic                                 is_del;
	logic                                 ins_ok;
	logic                                 del_ok;
	logic [CMP_W-1:0]                     at;
	logic [CMP_W-1:0]                     count_ext;
	logic [CMP_W-1:0]                     pos_ext;
	logic [IDX_W-1:0]                     at_idx;
	pli_pkg::status_t                     status_d;
	logic signed [pli_pkg::DATA_W-1:0]    removed_d;
	logic [CNT_W+pli_pkg::COUNT_W-1:0]    count_wide;

	logic signed [pli_pkg::DATA_W-1:0]    entry [DEPTH];
	pli_pkg::cell_ctl_t                   ctl   [DEPTH];

	// Handshake: a new request is taken unless a result is waiting stalled.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign count_ext = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(position);

	// Decode the request: target position and outcome.
	always_comb begin
		is_ins   = 1'b0;
		is_del   = 1'b0;
		at       = '0;
		status_d = pli_pkg::ST_RANGE;
		case (opcode)
			pli_pkg::OP_INS_FRONT: begin
				is_ins = 1'b1;
				at     = '0;
			end
			pli_pkg::OP_INS_BACK: begin
				is_ins = 1'b1;
				at     = count_ext;
			end
			pli_pkg::OP_INS_POS: begin
				is_ins = 1'b1;
				at     = pos_ext;
			end
			pli_pkg::OP_DEL_FRONT: begin
				is_del = 1'b1;
				at     = '0;
			end
			pli_pkg::OP_DEL_BACK: begin
				is_del = 1'b1;
				at     = count_ext - CMP_W'(1);
			end
			pli_pkg::OP_DEL_POS: begin
				is_del = 1'b1;
				at     = pos_ext;
			end
			default: begin
				is_ins = 1'b0;
				is_del = 1'b0;
			end
		endcase

		// Full and empty are checked before the position.
		if (is_ins) begin
			if (count_q == CNT_W'(DEPTH)) begin
				status_d = pli_pkg::ST_FULL;
			end else if (at > count_ext) begin
				status_d = pli_pkg::ST_RANGE;
			end else begin
				status_d = pli_pkg::ST_OK;
			end
		end else if (is_del) begin
			if (count_q == '0) begin
				status_d = pli_pkg::ST_EMPTY;
			end else if (at >= count_ext) begin
				status_d = pli_pkg::ST_RANGE;
			end else begin
				status_d = pli_pkg::ST_OK;
			end
		end
	end

	assign ins_ok = accept && is_ins && (status_d == pli_pkg::ST_OK);
	assign del_ok = accept && is_del && (status_d == pli_pkg::ST_OK);
	assign at_idx = at[IDX_W-1:0];

	// The removed word is read from the target cell before the shift.
	assign removed_d = (is_del && status_d == pli_pkg::ST_OK) ? entry[at_idx] : '0;

	// New occupancy after the request.
	always_comb begin
		count_d = count_q;
		if (ins_ok) begin
			count_d = count_q + CNT_W'(1);
		end else if (del_ok) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	assign count_wide = {{pli_pkg::COUNT_W{1'b0}}, count_d};

	// Row of cells, each told whether it is at or after the target.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [pli_pkg::DATA_W-1:0] left_w;
		logic signed [pli_pkg::DATA_W-1:0] right_w;

		assign ctl[i].ins  = ins_ok;
		assign ctl[i].del  = del_ok;
		assign ctl[i].hit  = (at == CMP_W'(i));
		assign ctl[i].past = (at < CMP_W'(i));

		if (i == 0) begin : g_first
			assign left_w = data_value;
		end else begin : g_mid_l
			assign left_w = entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = entry[i];
		end else begin : g_mid_r
			assign right_w = entry[i+1];
		end

		pli_cell u_cell (
			.clk   (clk),
			.ctl   (ctl[i]),
			.word  (data_value),
			.left  (left_w),
			.right (right_w),
			.entry (entry[i])
		);
	end

	// Occupancy and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			removed_q     <= removed_d;
			entry_count_q <= count_wide[pli_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = entry_count_q;

	// The count never exceeds the list depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("list count exceeds depth");

	// A failed request leaves the count unchanged.
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d != pli_pkg::ST_OK |=> count_q == $past(count_q))
		else $error("failed request changed the count");

	// A successful insert grows the list by exactly one.
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> count_q == CNT_W'($past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list by one");

	// Only a successful result carries a removed word.
	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != pli_pkg::ST_OK |-> removed_q == '0)
		else $error("failed result carries a removed word");

endmodule
`default_nettype wire
